// ===== design/serial_loaded_bank_mapper_defines.svh =====
`ifndef SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SBLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sblm same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define SBLM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sblm next-cycle check failed");

`endif

// ===== design/sblm_pkg.sv =====
`default_nettype none

package sblm_pkg;

  typedef enum logic [1:0] {
    FUNC_CPU_RD = 2'd0,
    FUNC_CPU_WR = 2'd1,
    FUNC_PPU_RD = 2'd2,
    FUNC_PPU_WR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } reg_sel_t;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  localparam logic [4:0] CONTROL_RESET   = 5'h0C;
  localparam logic [5:0] PRG_COUNT_RESET = 6'd16;
  localparam logic [2:0] LOAD_COUNT      = 3'd5;

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] shift_count;
    logic [4:0] control;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic [4:0] chr_whole_bank;
    logic [3:0] prg_whole_bank;
    logic [4:0] prg_low_bank;
    logic [4:0] prg_high_bank;
    logic [2:0] mirror_mode;
    logic [5:0] prg_bank_count;
    logic [4:0] chr_bank_count;
  } sblm_state_t;

  function automatic logic [4:0] last_bank(input logic [5:0] count);
    logic [5:0] m1;
    m1 = count - 6'd1;
    return m1[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/serial_loaded_bank_mapper.sv =====
// A result beat is registered and appears in the cycle after its access beat is accepted.
// Throughput: one access per cycle while m_tready holds; the output register frees in the cycle it is taken.
// Bank state updates on the accepting edge, so the next beat sees it at once.
// Reset (rst, synchronous): loader and bank registers clear, fixed-high PRG bank reloads
// to 15, control 0x0C, mirroring hardware, PRG bank count 16, CHR bank count 0, output
// register empty.
`default_nettype none
`include "serial_loaded_bank_mapper_defines.svh"

module serial_loaded_bank_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // xlat_addr[18:0], mirror[21:19], zero[23:22]
  output logic        m_tuser    // handled[0]
);
  import sblm_pkg::*;

  sblm_state_t st;
  logic [2:0]  mirror_next;
  logic        accept;
  logic        wr_en;
  logic        handled;
  logic [18:0] mapped;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (func_t'(s_tuser) == FUNC_CPU_WR) && s_tdata[15];

  sblm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .wr_en       (wr_en),
    .addr_sel    (s_tdata[14:13]),
    .data        (s_tdata[23:16]),
    .st          (st),
    .mirror_next (mirror_next)
  );

  sblm_xlate u_xlate (
    .st      (st),
    .func    (s_tuser),
    .addr    (s_tdata[15:0]),
    .handled (handled),
    .mapped  (mapped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'd0, mirror_next, mapped};
      m_tuser <= handled;
    end
  end

  `SBLM_ASSERT_NXT(a_accept_gives_beat, accept, m_tvalid)
  `SBLM_ASSERT_IMP(a_unclaimed_zero, m_tvalid && !m_tuser, m_tdata[18:0] == 19'd0)
  `SBLM_ASSERT_IMP(a_loader_bound, 1'b1, st.shift_count <= 3'd4)

endmodule

`default_nettype wire

// ===== design/sblm_regs.sv =====
`default_nettype none

module sblm_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic                 wr_en,
  input  logic [1:0]           addr_sel,
  input  logic [7:0]           data,
  output sblm_pkg::sblm_state_t st,
  output logic [2:0]           mirror_next
);
  import sblm_pkg::*;

  sblm_state_t st_next;
  logic [4:0]  sv;
  logic [2:0]  cnt;
  logic [5:0]  chr_dbl_m1;
  logic [4:0]  chr4k_mask;
  logic [4:0]  chr8k_mask;
  logic [4:0]  prg_half_m1;
  logic [3:0]  prg32k_mask;
  logic [4:0]  prg_last;

  assign sv          = {data[0], st.shift_value[4:1]};
  assign cnt         = st.shift_count + 3'd1;
  assign chr_dbl_m1  = {st.chr_bank_count, 1'b0} - 6'd1;
  assign chr4k_mask  = chr_dbl_m1[4:0];
  assign chr8k_mask  = st.chr_bank_count - 5'd1;
  assign prg_half_m1 = st.prg_bank_count[5:1] - 5'd1;
  assign prg32k_mask = (st.prg_bank_count > 6'd2) ? prg_half_m1[3:0] : 4'd0;
  assign prg_last    = last_bank(st.prg_bank_count);

  always_comb begin
    st_next = st;
    if (wr_en) begin
      if (data[7]) begin
        st_next.shift_value = '0;
        st_next.shift_count = '0;
        st_next.control     = st.control | CONTROL_RESET;
      end else begin
        st_next.shift_value = sv;
        st_next.shift_count = cnt;
        if (cnt == LOAD_COUNT) begin
          unique case (reg_sel_t'(addr_sel))
            SEL_CONTROL: begin
              st_next.control     = sv;
              st_next.mirror_mode = {1'b0, sv[1:0]} + 3'd1;
            end
            SEL_CHR_LOW: begin
              if (st.control[4]) begin
                st_next.chr_low_bank = sv & chr4k_mask;
              end else begin
                st_next.chr_whole_bank = sv & chr8k_mask;
              end
            end
            SEL_CHR_HIGH: begin
              if (st.control[4]) begin
                st_next.chr_high_bank = sv & chr4k_mask;
              end
            end
            SEL_PRG: begin
              if (!st.control[3]) begin
                st_next.prg_whole_bank = sv[4:1] & prg32k_mask;
              end else if (st.control[3:2] == PRG_MODE_FIX_FIRST) begin
                st_next.prg_high_bank = sv & prg_last;
              end else begin
                st_next.prg_low_bank = sv & prg_last;
              end
            end
            default: begin
              st_next.control = st.control;
            end
          endcase
          st_next.shift_value = '0;
          st_next.shift_count = '0;
        end
      end
    end
    if (cfg_we) begin
      if (cfg_index == CFG_PRG_BANK_COUNT) begin
        st_next.prg_bank_count = cfg_data;
        st_next.prg_high_bank  = last_bank(cfg_data);
      end else begin
        st_next.chr_bank_count = cfg_data[4:0];
      end
    end
  end

  assign mirror_next = st_next.mirror_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.shift_value    <= '0;
      st.shift_count    <= '0;
      st.control        <= CONTROL_RESET;
      st.chr_low_bank   <= '0;
      st.chr_high_bank  <= '0;
      st.chr_whole_bank <= '0;
      st.prg_whole_bank <= '0;
      st.prg_low_bank   <= '0;
      st.prg_high_bank  <= last_bank(PRG_COUNT_RESET);
      st.mirror_mode    <= '0;
      st.prg_bank_count <= PRG_COUNT_RESET;
      st.chr_bank_count <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sblm_xlate.sv =====
`default_nettype none

module sblm_xlate (
  input  sblm_pkg::sblm_state_t st,
  input  logic [1:0]            func,
  input  logic [15:0]           addr,
  output logic                  handled,
  output logic [18:0]           mapped
);
  import sblm_pkg::*;

  logic [18:0] prg_addr;
  logic [18:0] chr_addr;
  logic        chr_ram;
  logic        ppu_low;

  assign chr_ram = (st.chr_bank_count == 5'd0);
  assign ppu_low = (addr[15:13] == 3'd0);

  always_comb begin
    if (!st.control[3]) begin
      prg_addr = {st.prg_whole_bank, addr[14:0]};
    end else if (st.control[3:2] == PRG_MODE_FIX_FIRST) begin
      prg_addr = {(addr[14] ? st.prg_high_bank : 5'd0), addr[13:0]};
    end else begin
      prg_addr = {(addr[14] ? last_bank(st.prg_bank_count) : st.prg_low_bank), addr[13:0]};
    end
  end

  always_comb begin
    if (chr_ram) begin
      chr_addr = {3'd0, addr};
    end else if (st.control[4]) begin
      chr_addr = {2'd0, (addr[12] ? st.chr_high_bank : st.chr_low_bank), addr[11:0]};
    end else begin
      chr_addr = {1'b0, st.chr_whole_bank, addr[12:0]};
    end
  end

  always_comb begin
    handled = 1'b0;
    mapped  = '0;
    unique case (func_t'(func))
      FUNC_CPU_RD: begin
        if (addr[15]) begin
          handled = 1'b1;
          mapped  = prg_addr;
        end
      end
      FUNC_CPU_WR: begin
        handled = addr[15];
      end
      FUNC_PPU_RD: begin
        if (ppu_low) begin
          handled = 1'b1;
          mapped  = chr_addr;
        end
      end
      FUNC_PPU_WR: begin
        if (ppu_low && chr_ram) begin
          handled = 1'b1;
          mapped  = {3'd0, addr};
        end
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
  import sblm_pkg::*;

  typedef struct packed {
    logic        handled;
    logic [18:0] xlat_addr;
    logic [2:0]  mirror;
  } access_result_t;

  localparam int STALL_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // addr[15:0], data[23:16]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // xlat_addr[18:0], mirror[21:19], zero[23:22]
  logic        m_tuser;        // handled[0]

  access_result_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  int rx_hold = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;

  logic [5:0] prg_count;
  logic [4:0] chr_count;
  logic [4:0] shift_q;
  logic [2:0] shift_cnt;
  logic [4:0] ctrl_q;
  logic [4:0] chr_low_q;
  logic [4:0] chr_high_q;
  logic [4:0] chr_whole_q;
  logic [3:0] prg_whole_q;
  logic [4:0] prg_low_q;
  logic [4:0] prg_high_q;
  logic [2:0] mirror_q;

  serial_loaded_bank_mapper i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [4:0] final_prg_bank();
    logic [5:0] m;
    m = prg_count - 6'd1;
    return m[4:0];
  endfunction

  function automatic access_result_t map_access(func_t f, logic [15:0] a, logic [7:0] d);
    access_result_t r;
    logic [1:0] mode;
    logic [4:0] v;
    logic [5:0] wide_mask;
    logic [4:0] chr_pair_mask;
    logic [5:0] half_m1;
    r = '0;
    mode = ctrl_q[3:2];
    wide_mask = {chr_count, 1'b0} - 6'd1;
    chr_pair_mask = wide_mask[4:0];
    half_m1 = prg_count / 6'd2 - 6'd1;
    case (f)
      FUNC_CPU_RD: begin
        if (a[15]) begin
          r.handled = 1'b1;
          if (mode < PRG_MODE_FIX_FIRST)
            r.xlat_addr = {prg_whole_q, a[14:0]};
          else if (mode == PRG_MODE_FIX_FIRST)
            r.xlat_addr = {(a[14] ? prg_high_q : 5'd0), a[13:0]};
          else
            r.xlat_addr = {(a[14] ? final_prg_bank() : prg_low_q), a[13:0]};
        end
      end
      FUNC_CPU_WR: begin
        if (a[15]) begin
          r.handled = 1'b1;
          if (d[7]) begin
            shift_q = '0;
            shift_cnt = '0;
            ctrl_q = ctrl_q | CONTROL_RESET;
          end else begin
            shift_q = {d[0], shift_q[4:1]};
            shift_cnt = shift_cnt + 3'd1;
            if (shift_cnt == LOAD_COUNT) begin
              v = shift_q;
              case (reg_sel_t'(a[14:13]))
                SEL_CONTROL: begin
                  ctrl_q = v;
                  mirror_q = {1'b0, v[1:0]} + 3'd1;
                end
                SEL_CHR_LOW: begin
                  if (ctrl_q[4]) chr_low_q = v & chr_pair_mask;
                  else chr_whole_q = v & (chr_count - 5'd1);
                end
                SEL_CHR_HIGH: begin
                  if (ctrl_q[4]) chr_high_q = v & chr_pair_mask;
                end
                default: begin
                  if (mode < PRG_MODE_FIX_FIRST)
                    prg_whole_q = (prg_count > 6'd2) ? (v[4:1] & half_m1[3:0]) : 4'd0;
                  else if (mode == PRG_MODE_FIX_FIRST)
                    prg_high_q = v & final_prg_bank();
                  else
                    prg_low_q = v & final_prg_bank();
                end
              endcase
              shift_q = '0;
              shift_cnt = '0;
            end
          end
        end
      end
      FUNC_PPU_RD: begin
        if (a[15:13] == 3'b000) begin
          r.handled = 1'b1;
          if (chr_count == 5'd0)
            r.xlat_addr = {3'b000, a};
          else if (ctrl_q[4])
            r.xlat_addr = {2'b00, (a[12] ? chr_high_q : chr_low_q), a[11:0]};
          else
            r.xlat_addr = {1'b0, chr_whole_q, a[12:0]};
        end
      end
      default: begin
        if (a[15:13] == 3'b000 && chr_count == 5'd0) begin
          r.handled = 1'b1;
          r.xlat_addr = {3'b000, a};
        end
      end
    endcase
    r.mirror = mirror_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PRG_BANK_COUNT) begin
      prg_count = val;
      prg_high_q = final_prg_bank();
    end else begin
      chr_count = val[4:0];
    end
  endtask

  task automatic send_access(func_t f, logic [15:0] a, logic [7:0] d);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {d, a};
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(map_access(f, a, d));
    items_sent++;
  endtask

  task automatic shift_bit(logic bit_val, reg_sel_t sel);
    bit [31:0] rnd;
    logic [15:0] a;
    logic [7:0] d;
    rnd = $urandom;
    a = rnd[15:0];
    a[15] = 1'b1;
    a[14:13] = sel;
    d = rnd[23:16];
    d[7] = 1'b0;
    d[0] = bit_val;
    send_access(FUNC_CPU_WR, a, d);
  endtask

  task automatic load_reg(reg_sel_t sel, logic [4:0] val);
    for (int i = 0; i < 5; i++) shift_bit(val[i], sel);
  endtask

  task automatic random_access();
    bit [31:0] rnd;
    func_t f;
    logic [15:0] a;
    rnd = $urandom;
    f = func_t'(rnd[1:0]);
    a = rnd[31:16];
    if (rnd[2]) begin
      if (f == FUNC_CPU_RD || f == FUNC_CPU_WR) a[15] = 1'b1;
      else a[15:13] = 3'b000;
    end
    send_access(f, a, rnd[15:8]);
  endtask

  task automatic test_reset_map();
    send_access(FUNC_CPU_RD, 16'h8000, 8'h00);
    send_access(FUNC_CPU_RD, 16'hFFFF, 8'hFF);
    send_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);
    send_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);
    send_access(FUNC_PPU_RD, 16'h1FFF, 8'h00);
    send_access(FUNC_PPU_RD, 16'h2000, 8'h00);
    send_access(FUNC_PPU_WR, 16'h0000, 8'hFF);
    send_access(FUNC_PPU_WR, 16'hFFFF, 8'h00);
  endtask

  task automatic test_serial_load();
    write_cfg(CFG_PRG_BANK_COUNT, 6'd32);
    write_cfg(CFG_CHR_BANK_COUNT, 6'd16);
    load_reg(SEL_CHR_HIGH, 5'd3);
    load_reg(SEL_CONTROL, 5'b10010);
    shift_bit(1'b1, SEL_PRG);
    shift_bit(1'b0, SEL_PRG);
    send_access(FUNC_CPU_WR, 16'hE000, 8'h80);
    send_access(FUNC_CPU_RD, 16'hBFFF, 8'h00);
    send_access(FUNC_CPU_RD, 16'hC000, 8'h00);
    send_access(FUNC_PPU_RD, 16'h1000, 8'h00);
    send_access(FUNC_PPU_WR, 16'h0000, 8'h55);
  endtask

  task automatic test_random_traffic();
    bit [31:0] rnd;
    logic [5:0] prg;
    logic [5:0] chr;
    int choice;
    int stop_at;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin prg = 6'd32; chr = 6'd16; end
        1: begin prg = 6'd1; chr = 6'd0; end
        2: begin prg = 6'd2; chr = 6'd1; end
        default: begin
          prg = 6'd1 << $urandom_range(0, 5);
          chr = ($urandom_range(0, 5) == 0) ? 6'd0 : 6'd1 << $urandom_range(0, 4);
        end
      endcase
      tx_idle_on = (p != 0) && (p != 2);
      rx_idle_on = (p != 0) && (p != 1);
      write_cfg(CFG_PRG_BANK_COUNT, prg);
      write_cfg(CFG_CHR_BANK_COUNT, chr);
      stop_at = items_sent + 135;
      while (items_sent < stop_at) begin
        choice = $urandom_range(0, 99);
        rnd = $urandom;
        if (choice < 45) begin
          load_reg(reg_sel_t'(rnd[1:0]), rnd[6:2]);
          repeat ($urandom_range(1, 3)) random_access();
        end else if (choice < 60) begin
          repeat ($urandom_range(1, 4)) shift_bit(rnd[3], reg_sel_t'(rnd[1:0]));
        end else if (choice < 68) begin
          send_access(FUNC_CPU_WR, {1'b1, rnd[14:0]}, {1'b1, rnd[22:16]});
        end else if (choice == 68) begin
          wait_drained();
        end else begin
          random_access();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle_on) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    access_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.handled) report_mismatch("handled", m_tuser, want.handled);
        if (m_tdata[18:0] !== want.xlat_addr)
          report_mismatch("xlat_addr", m_tdata[18:0], want.xlat_addr);
        if (m_tdata[21:19] !== want.mirror)
          report_mismatch("mirror", m_tdata[21:19], want.mirror);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    prg_count = PRG_COUNT_RESET;
    chr_count = '0;
    shift_q = '0;
    shift_cnt = '0;
    ctrl_q = CONTROL_RESET;
    chr_low_q = '0;
    chr_high_q = '0;
    chr_whole_q = '0;
    prg_whole_q = '0;
    prg_low_q = '0;
    prg_high_q = final_prg_bank();
    mirror_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_map();
    test_serial_load();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
